// ----- rtl/nsng_pkg.sv -----
`default_nettype none

package nsng_pkg;

   // sequence length and derived widths
   localparam int MAX_INDEX = 2048;
   localparam int ADDR_W    = (MAX_INDEX > 1) ? $clog2(MAX_INDEX) : 1;
   localparam int CNT_W     = $clog2(MAX_INDEX + 1);

   // fixed field and store widths
   localparam int INDEX_W   = 12;
   localparam int VALUE_W   = 31;
   localparam int STORE_W   = 34;
   localparam int PROD_W    = STORE_W + 3;

   localparam logic [STORE_W-1:0] STORE_MAX = {STORE_W{1'b1}};
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   // controller to datapath commands
   typedef struct packed {
      logic init;
      logic step;
   } nsng_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic fill_done;
   } nsng_status_type;

endpackage

`default_nettype wire

// ----- rtl/nth_smooth_number_generator.sv -----
// Returns the n-th number whose only prime factors are 2, 3 and 5 (index 1
// gives 1; index 0 reads as 1 and indexes above 2048 read as 2048). Each
// request rebuilds the sequence from 1 by an ordered merge of three store
// pointers, one new entry per READ and CALC state pair, since each step
// waits on the registered read of the sequence store before it can append.
// Once a request is taken, busy stays high through the READ, CALC and FINISH
// states; a new request is taken only in idle; rsp_valid is high for exactly
// one cycle, the last busy cycle, and the result must be taken in that cycle,
// as the block cannot be stalled. Values above 2147483647 come back as
// 2147483647 with rsp_overflow set. No clearing pass is needed after reset.
`default_nettype none

module nth_smooth_number_generator
   import nsng_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [INDEX_W-1:0] req_index,
   output logic                    rsp_valid,
   output logic      [VALUE_W-1:0] rsp_smooth_value,
   output logic                    rsp_overflow
);

   nsng_cmd_type    cmd;
   nsng_status_type status;

   // sequencing
   nsng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // merge datapath and sequence store
   nsng_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_index        (req_index),
      .rsp_smooth_value (rsp_smooth_value),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

`default_nettype wire

// ----- rtl/nsng_ram.sv -----
`default_nettype none

module nsng_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/nsng_ctrl.sv -----
`default_nettype none

module nsng_ctrl
   import nsng_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   output logic                 rsp_valid,
   output nsng_cmd_type         cmd,
   input  wire nsng_status_type status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_CALC   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd.init = 1'b0;
      cmd.step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.init = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = status.fill_done ? ST_FINISH : ST_CALC;
         end
         ST_CALC: begin
            cmd.step = 1'b1;
            state_in = ST_READ;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_FINISH);

endmodule

`default_nettype wire

// ----- rtl/nsng_datapath.sv -----
`default_nettype none

module nsng_datapath
   import nsng_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire nsng_cmd_type       cmd,
   output nsng_status_type         status,
   input  wire logic [INDEX_W-1:0] req_index,
   output logic      [VALUE_W-1:0] rsp_smooth_value,
   output logic                    rsp_overflow
);

   logic [ADDR_W-1:0]  ptr2_ff, ptr3_ff, ptr5_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   target_ff;
   logic [CNT_W-1:0]   target_in;
   logic [STORE_W-1:0] last_ff;

   logic [STORE_W-1:0] rd2, rd3, rd5;
   logic [PROD_W-1:0]  prod2, prod3, prod5;
   logic [STORE_W-1:0] cand2, cand3, cand5;
   logic [STORE_W-1:0] min_val;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [STORE_W-1:0] wr_data;

   // clamp the requested position into 1..MAX_INDEX
   always_comb begin
      if (req_index == '0) begin
         target_in = CNT_W'(1);
      end else if (int'(req_index) > MAX_INDEX) begin
         target_in = CNT_W'(MAX_INDEX);
      end else begin
         target_in = CNT_W'(req_index);
      end
   end

   // candidates times 2, 3 and 5, capped to the store width
   assign prod2 = {3'b000, rd2} << 1;
   assign prod3 = ({3'b000, rd3} << 1) + {3'b000, rd3};
   assign prod5 = ({3'b000, rd5} << 2) + {3'b000, rd5};

   assign cand2 = (prod2 > PROD_W'(STORE_MAX)) ? STORE_MAX : prod2[STORE_W-1:0];
   assign cand3 = (prod3 > PROD_W'(STORE_MAX)) ? STORE_MAX : prod3[STORE_W-1:0];
   assign cand5 = (prod5 > PROD_W'(STORE_MAX)) ? STORE_MAX : prod5[STORE_W-1:0];

   // smallest candidate
   always_comb begin
      min_val = cand2;
      if (cand3 < min_val) begin
         min_val = cand3;
      end
      if (cand5 < min_val) begin
         min_val = cand5;
      end
   end

   // write port: seed entry zero on init, append the minimum on each step
   assign wr_en   = cmd.init | cmd.step;
   assign wr_addr = cmd.init ? '0 : fill_ff[ADDR_W-1:0];
   assign wr_data = cmd.init ? STORE_W'(1) : min_val;

   // three copies of the sequence store, one per read pointer
   nsng_ram #(.WIDTH(STORE_W), .DEPTH(MAX_INDEX)) u_ram2 (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr2_ff),
      .rd_data (rd2)
   );

   nsng_ram #(.WIDTH(STORE_W), .DEPTH(MAX_INDEX)) u_ram3 (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr3_ff),
      .rd_data (rd3)
   );

   nsng_ram #(.WIDTH(STORE_W), .DEPTH(MAX_INDEX)) u_ram5 (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr5_ff),
      .rd_data (rd5)
   );

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr2_ff <= '0;
         ptr3_ff <= '0;
         ptr5_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.init) begin
         ptr2_ff <= '0;
         ptr3_ff <= '0;
         ptr5_ff <= '0;
         fill_ff <= CNT_W'(1);
      end else if (cmd.step) begin
         if (cand2 == min_val) begin
            ptr2_ff <= ptr2_ff + ADDR_W'(1);
         end
         if (cand3 == min_val) begin
            ptr3_ff <= ptr3_ff + ADDR_W'(1);
         end
         if (cand5 == min_val) begin
            ptr5_ff <= ptr5_ff + ADDR_W'(1);
         end
         fill_ff <= fill_ff + CNT_W'(1);
      end
   end

   // target and the most recently appended entry
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         target_ff <= target_in;
         last_ff   <= STORE_W'(1);
      end else if (cmd.step) begin
         last_ff   <= min_val;
      end
   end

   assign status.fill_done = (fill_ff >= target_ff);

   // saturate the answer to the result width
   assign rsp_overflow     = (last_ff > STORE_W'(VALUE_MAX));
   assign rsp_smooth_value = rsp_overflow ? VALUE_MAX : last_ff[VALUE_W-1:0];

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;
   import nsng_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // longest quiet stretch of a correct run is one full rebuild plus a long gap
   localparam int WATCHDOG_LIMIT = 6 * (2 * MAX_INDEX + 1) + 200;
   localparam int RANDOM_WORDS   = 266;
   localparam int DIRECTED_WORDS = 24;
   localparam int TAIL_CYCLES    = 50;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               ovf;
   } smooth_word_type;

   typedef struct {
      logic [INDEX_W-1:0] index;
      bit                 known;
      logic [VALUE_W-1:0] value;
      logic               ovf;
   } query_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [INDEX_W-1:0] req_index = '0;
   logic               busy;
   logic               rsp_valid;
   logic [VALUE_W-1:0] rsp_smooth_value;
   logic               rsp_overflow;

   // results still owed by the block, oldest first
   smooth_word_type pending_smooth_q[$];
   int unsigned     mismatch_count = 0;
   int unsigned     idle_cycles = 0;

   // private copy of the merge state
   logic [STORE_W-1:0] seq_mem [MAX_INDEX];
   logic [ADDR_W-1:0]  ptr_two;
   logic [ADDR_W-1:0]  ptr_three;
   logic [ADDR_W-1:0]  ptr_five;
   int unsigned        fill_cnt;

   // directed queries: small indexes, overflow boundary, saturated indexes
   query_row_type directed_rows [DIRECTED_WORDS] = '{
      '{12'd0,    1'b1, 31'd1,     1'b0},
      '{12'd1,    1'b1, 31'd1,     1'b0},
      '{12'd2,    1'b1, 31'd2,     1'b0},
      '{12'd3,    1'b1, 31'd3,     1'b0},
      '{12'd4,    1'b1, 31'd4,     1'b0},
      '{12'd5,    1'b1, 31'd5,     1'b0},
      '{12'd6,    1'b1, 31'd6,     1'b0},
      '{12'd7,    1'b1, 31'd8,     1'b0},
      '{12'd8,    1'b1, 31'd9,     1'b0},
      '{12'd9,    1'b1, 31'd10,    1'b0},
      '{12'd10,   1'b1, 31'd12,    1'b0},
      '{12'd20,   1'b0, 31'd0,     1'b0},
      '{12'd100,  1'b0, 31'd0,     1'b0},
      '{12'd600,  1'b0, 31'd0,     1'b0},
      '{12'd1690, 1'b0, 31'd0,     1'b0},
      '{12'd1691, 1'b0, 31'd0,     1'b0},
      '{12'd1692, 1'b0, 31'd0,     1'b0},
      '{12'd1693, 1'b0, 31'd0,     1'b0},
      '{12'd2047, 1'b0, 31'd0,     1'b0},
      '{12'd2048, 1'b1, VALUE_MAX, 1'b1},
      '{12'd2049, 1'b1, VALUE_MAX, 1'b1},
      '{12'h555,  1'b0, 31'd0,     1'b0},
      '{12'hAAA,  1'b1, VALUE_MAX, 1'b1},
      '{12'hFFF,  1'b1, VALUE_MAX, 1'b1}
   };

   nth_smooth_number_generator uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_index        (req_index),
      .rsp_valid        (rsp_valid),
      .rsp_smooth_value (rsp_smooth_value),
      .rsp_overflow     (rsp_overflow)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // clamp a product to the store width
   function automatic logic [STORE_W-1:0] clamp_store(input logic [PROD_W-1:0] prod);
      return (prod > {3'b000, STORE_MAX}) ? STORE_MAX : prod[STORE_W-1:0];
   endfunction

   // rebuild the sequence up to the requested index and read the answer
   function automatic void predict_smooth(input logic [INDEX_W-1:0] idx,
                                          output logic [VALUE_W-1:0] value,
                                          output logic ovf);
      int unsigned        n;
      logic [STORE_W-1:0] cand_two;
      logic [STORE_W-1:0] cand_three;
      logic [STORE_W-1:0] cand_five;
      logic [STORE_W-1:0] least;
      logic [STORE_W-1:0] answer;
      n = 32'(idx);
      if (n == 0) n = 1;
      if (n > MAX_INDEX) n = MAX_INDEX;
      seq_mem[0] = STORE_W'(1);
      ptr_two    = '0;
      ptr_three  = '0;
      ptr_five   = '0;
      fill_cnt   = 1;
      while (fill_cnt < n) begin
         cand_two   = clamp_store({3'b000, seq_mem[ptr_two]} * 2);
         cand_three = clamp_store({3'b000, seq_mem[ptr_three]} * 3);
         cand_five  = clamp_store({3'b000, seq_mem[ptr_five]} * 5);
         least = cand_two;
         if (cand_three < least) least = cand_three;
         if (cand_five < least) least = cand_five;
         seq_mem[fill_cnt] = least;
         fill_cnt++;
         // every pointer that hit the minimum moves, so no duplicates
         if (cand_two == least) ptr_two++;
         if (cand_three == least) ptr_three++;
         if (cand_five == least) ptr_five++;
      end
      answer = seq_mem[n - 1];
      if (answer > {3'b000, VALUE_MAX}) begin
         value = VALUE_MAX;
         ovf   = 1'b1;
      end else begin
         value = answer[VALUE_W-1:0];
         ovf   = 1'b0;
      end
   endfunction

   // mostly back to back or short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // mostly cheap indexes, some deep ones, a few over the full field
   function automatic logic [INDEX_W-1:0] pick_index();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) return INDEX_W'($urandom_range(0, 150));
      if (r < 92) return INDEX_W'($urandom_range(151, MAX_INDEX - 1));
      return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
   endfunction

   // issue one word, record what it must return, then maybe pause
   task automatic issue_query(input logic [INDEX_W-1:0] idx, input bit known,
                              input logic [VALUE_W-1:0] known_value,
                              input logic known_ovf, input bit allow_gap);
      smooth_word_type w;
      int unsigned     gap;
      if (known) begin
         w.value = known_value;
         w.ovf   = known_ovf;
      end else begin
         predict_smooth(idx, w.value, w.ovf);
      end
      start     <= 1'b1;
      req_index <= idx;
      do @(posedge clock); while (busy);
      pending_smooth_q.push_back(w);
      gap = allow_gap ? pick_gap() : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every owed result has come back
   task automatic drain_results();
      if (pending_smooth_q.size() != 0) begin
         start <= 1'b0;
         while (pending_smooth_q.size() != 0) @(posedge clock);
      end
   endtask

   // compare each result word with the oldest owed one
   always @(posedge clock) begin
      smooth_word_type w;
      if (!reset && rsp_valid) begin
         if (pending_smooth_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result word: value %0d overflow %0b",
                        rsp_smooth_value, rsp_overflow);
         end else begin
            w = pending_smooth_q.pop_front();
            if (rsp_smooth_value !== w.value || rsp_overflow !== w.ovf) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result mismatch: expected value %0d overflow %0b, got %0d %0b",
                           w.value, w.ovf, rsp_smooth_value, rsp_overflow);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit quiet_stretch;
      quiet_stretch = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed_rows[i])
         issue_query(directed_rows[i].index, directed_rows[i].known,
                     directed_rows[i].value, directed_rows[i].ovf, 1'b1);
      drain_results();

      // random part, stretches of 40 words with or without gaps, chosen at random
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 40 == 0) quiet_stretch = ($urandom_range(0, 2) == 0);
         if (i == RANDOM_WORDS / 2) drain_results();
         issue_query(pick_index(), 1'b0, '0, 1'b0, !quiet_stretch);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/nsng_pkg.sv
rtl/nsng_ram.sv
rtl/nsng_ctrl.sv
rtl/nsng_datapath.sv
rtl/nth_smooth_number_generator.sv
tb/sv/testbench.sv
